/* rtl/drd_pkg.sv */
// Shared types and constants for the detection row decoder.
// Word formats of the request and response channels and the per-axis clip result.
// No dependencies.
package drd_pkg;

   localparam int NUM_CLASSES  = 4;
   localparam int SCORE_FIELDS = 4;
   localparam int SCAN_CLASSES = (NUM_CLASSES < SCORE_FIELDS) ? NUM_CLASSES : SCORE_FIELDS;
   localparam int SCORE_W      = 16;
   localparam int COORD_W      = 16;
   localparam int SCALE_W      = 16;
   localparam int FRAME_W      = 13;
   localparam int PROD_W       = COORD_W + SCALE_W;
   localparam int CSR_INDEX_W  = 3;
   localparam int CSR_DATA_W   = 16;

   localparam logic [FRAME_W-1:0] MAX_FRAME = 13'd4096;

   // Register indexes of the csr port.
   localparam logic [CSR_INDEX_W-1:0] CSR_CONF_THRESHOLD = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_WIDTH    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCALE_X        = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCALE_Y        = 3'd4;

   typedef struct packed {
      logic [15:0] box_ctr_x;
      logic [15:0] box_ctr_y;
      logic [15:0] box_width_in;
      logic [15:0] box_height_in;
      logic [15:0] objectness;
      logic [15:0] class_score_0;
      logic [15:0] class_score_1;
      logic [15:0] class_score_2;
      logic [15:0] class_score_3;
   } req_word_type;

   typedef struct packed {
      logic [1:0]  class_id;
      logic [15:0] confidence;
      logic [11:0] box_x;
      logic [11:0] box_y;
      logic [12:0] box_w;
      logic [12:0] box_h;
   } rsp_word_type;

   // Clipped span on one axis.
   typedef struct packed {
      logic        keep;
      logic [11:0] start;
      logic [12:0] len;
   } axis_type;

endpackage

/* rtl/drd_axis.sv */
// One axis of the box: corner from scaled centre and size, truncation, clip to frame.
// Purely combinational. Depends on drd_pkg.
module drd_axis
   import drd_pkg::*;
(
   input  logic [PROD_W-1:0]  center_prod,  // Q12.20
   input  logic [PROD_W-1:0]  size_prod,    // Q12.20
   input  logic [FRAME_W-1:0] bound,
   output axis_type           span
);

   logic signed [PROD_W+1:0] diff;    // center - size/2, Q.21
   logic        [PROD_W+1:0] mag;
   logic                     neg;
   logic signed [13:0]       left;
   logic        [11:0]       size_int;
   logic signed [14:0]       hi_end;
   logic signed [14:0]       lo_clip;
   logic signed [14:0]       hi_clip;
   logic signed [14:0]       len;

   always_comb begin
      diff     = $signed({1'b0, center_prod, 1'b0}) - $signed({2'b00, size_prod});
      neg      = diff[PROD_W+1];
      mag      = neg ? (~diff + 1'b1) : diff;
      // truncate toward zero: shift the magnitude, restore the sign
      left     = neg ? -$signed({1'b0, mag[PROD_W+1:21]}) : $signed({1'b0, mag[PROD_W+1:21]});
      size_int = size_prod[PROD_W-1:20];
      hi_end   = {left[13], left} + $signed({3'b000, size_int});
      lo_clip  = left[13] ? 15'sd0 : {left[13], left};
      hi_clip  = (hi_end < $signed({2'b00, bound})) ? hi_end : $signed({2'b00, bound});
      len      = hi_clip - lo_clip;
      span.keep  = (len > 15'sd0);
      span.start = lo_clip[11:0];
      span.len   = len[12:0];
   end

endmodule

/* rtl/detection_row_decode.sv */
// Top level of the detection row decoder: csr registers, three-stage pipeline.
// Depends on drd_pkg and drd_axis.
//
// Usage:
//  - req channel: one detector row per word (centre, size, objectness, four
//    class scores). A word is taken at a clock edge with req_valid high and
//    req_stall low.
//  - rsp channel: zero or one detection per row (class, confidence, clipped
//    box). Rows that fail the objectness or confidence threshold, have no
//    positive class score or end up with an empty box give no word.
//  - csr port: csr_we/csr_index/csr_wdata write threshold, frame size and
//    scales; write only while the pipeline is empty. Indexes past the list
//    are ignored.
//  - Order: an accepted row passes the input, product and output registers in turn.
//  - Throughput: one row per cycle while rsp_stall is low; the three pipeline
//    registers each advance whenever the stage after them is empty or moving.
//  - Stall: rsp_stall holds the output word; the stages behind it keep filling
//    until all three are full, then req_stall rises.
//  - Reset (synchronous) empties the pipeline and loads the csr defaults:
//    threshold 0.25, frame 640x640, scales 1.0.
module detection_row_decode
   import drd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_word_type           req_data,
   // response channel
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_word_type           rsp_data,
   // csr write port
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   // csr registers
   logic [SCORE_W-1:0] threshold_ff;
   logic [FRAME_W-1:0] frame_width_ff;
   logic [FRAME_W-1:0] frame_height_ff;
   logic [SCALE_W-1:0] scale_x_ff;
   logic [SCALE_W-1:0] scale_y_ff;
   logic [FRAME_W-1:0] bound_x;
   logic [FRAME_W-1:0] bound_y;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff    <= 16'd16384;
         frame_width_ff  <= 13'd640;
         frame_height_ff <= 13'd640;
         scale_x_ff      <= 16'd16384;
         scale_y_ff      <= 16'd16384;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_CONF_THRESHOLD: threshold_ff    <= csr_wdata;
            CSR_FRAME_WIDTH:    frame_width_ff  <= csr_wdata[FRAME_W-1:0];
            CSR_FRAME_HEIGHT:   frame_height_ff <= csr_wdata[FRAME_W-1:0];
            CSR_SCALE_X:        scale_x_ff      <= csr_wdata;
            CSR_SCALE_Y:        scale_y_ff      <= csr_wdata;
            default: ;
         endcase
      end
   end

   // clip bound saturates at the largest frame
   assign bound_x = (frame_width_ff  > MAX_FRAME) ? MAX_FRAME : frame_width_ff;
   assign bound_y = (frame_height_ff > MAX_FRAME) ? MAX_FRAME : frame_height_ff;

   // pipeline handshake: a stage loads when it is empty or its word moves on
   logic s1_valid_ff, s2_valid_ff, rsp_valid_ff;
   logic ready1, ready2, ready3;

   assign ready3    = !rsp_valid_ff || !rsp_stall;
   assign ready2    = !s2_valid_ff  || ready3;
   assign ready1    = !s1_valid_ff  || ready2;
   assign req_stall = !ready1;
   assign rsp_valid = rsp_valid_ff;

   // stage 1: input register
   req_word_type s1_word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (ready1) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ready1 && req_valid) begin
         s1_word_ff <= req_data;
      end
   end

   // argmax over class scores: strictly greater wins, so ties keep the first
   logic [SCORE_W-1:0] scores [SCORE_FIELDS];
   logic [SCORE_W-1:0] best;
   logic [1:0]         best_id;
   logic               best_found;

   always_comb begin
      scores[0]  = s1_word_ff.class_score_0;
      scores[1]  = s1_word_ff.class_score_1;
      scores[2]  = s1_word_ff.class_score_2;
      scores[3]  = s1_word_ff.class_score_3;
      best       = '0;
      best_id    = '0;
      best_found = 1'b0;
      for (int i = 0; i < SCAN_CLASSES; i++) begin
         if (scores[i] > best) begin
            best       = scores[i];
            best_id    = i[1:0];
            best_found = 1'b1;
         end
      end
   end

   // stage 2: products registered
   logic [PROD_W-1:0]  conf_prod;
   logic [SCORE_W-1:0] conf_ff;
   logic [1:0]         class_id_ff;
   logic               pass_ff;      // objectness ok and some class positive
   logic [PROD_W-1:0]  cx_prod_ff, cy_prod_ff, w_prod_ff, h_prod_ff;

   assign conf_prod = s1_word_ff.objectness * best;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (ready2) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ready2 && s1_valid_ff) begin
         conf_ff     <= conf_prod[PROD_W-1:SCORE_W];
         class_id_ff <= best_id;
         pass_ff     <= best_found && (s1_word_ff.objectness >= threshold_ff);
         cx_prod_ff  <= s1_word_ff.box_ctr_x     * scale_x_ff;
         w_prod_ff   <= s1_word_ff.box_width_in  * scale_x_ff;
         cy_prod_ff  <= s1_word_ff.box_ctr_y     * scale_y_ff;
         h_prod_ff   <= s1_word_ff.box_height_in * scale_y_ff;
      end
   end

   // box corner, truncation and clip per axis
   axis_type span_x, span_y;
   logic     keep;

   drd_axis u_axis_x (
      .center_prod (cx_prod_ff),
      .size_prod   (w_prod_ff),
      .bound       (bound_x),
      .span        (span_x)
   );

   drd_axis u_axis_y (
      .center_prod (cy_prod_ff),
      .size_prod   (h_prod_ff),
      .bound       (bound_y),
      .span        (span_y)
   );

   assign keep = pass_ff && (conf_ff >= threshold_ff) && span_x.keep && span_y.keep;

   // stage 3: output register; dropped rows just leave it empty
   rsp_word_type rsp_word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ready3) begin
         rsp_valid_ff <= s2_valid_ff && keep;
      end
   end

   always_ff @(posedge clock) begin
      if (ready3 && s2_valid_ff && keep) begin
         rsp_word_ff.class_id   <= class_id_ff;
         rsp_word_ff.confidence <= conf_ff;
         rsp_word_ff.box_x      <= span_x.start;
         rsp_word_ff.box_y      <= span_y.start;
         rsp_word_ff.box_w      <= span_x.len;
         rsp_word_ff.box_h      <= span_y.len;
      end
   end

   assign rsp_data = rsp_word_ff;

endmodule
